// ===== rtl/bclk_pkg.sv =====
package bclk_pkg;

    localparam int unsigned MAX_PINS   = 8;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned INTERVAL_W = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PIN_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLICK_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_ENABLE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TIME    = 3'd4;

    localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RESET = 16'd50;
    localparam logic [INTERVAL_W-1:0] LONG_TIME_RESET    = 16'd1000;

    typedef struct packed {
        logic [MAX_PINS-1:0] pressed_mask;
        logic [MAX_PINS-1:0] long_click_mask;
        logic [MAX_PINS-1:0] click_mask;
        logic                sample_taken;
    } t_result;

endpackage

// ===== rtl/button_click_long_click_detector.sv =====
// an input transaction is captured in the input register, and its result is then registered
// in the output register, from which the output transaction is offered
// throughput: one sample per cycle unless the output stalls; the per-sample state update is combinational
// the output register lets a new sample be taken while a result waits
// reset (synchronous, active low): masks cleared, interval 50 ms, long click 1000 ms,
// all pins released, last sample time and press times zero
module button_click_long_click_detector #(
    parameter int unsigned NUM_PINS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // now_ms [31:0], port_sample [39:32]
    input  logic [bclk_pkg::IN_DATA_W-1:0]     i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // sample_taken [0], click_mask [8:1], long_click_mask [16:9], pressed_mask [24:17], zeros above
    output logic [bclk_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    input  logic                               i_cfg_we,
    input  logic [bclk_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bclk_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int unsigned LANES = (NUM_PINS < bclk_pkg::MAX_PINS) ? NUM_PINS
                                                                    : bclk_pkg::MAX_PINS;
    localparam int unsigned PAD_W = bclk_pkg::OUT_DATA_W - $bits(bclk_pkg::t_result);

    // configuration
    logic [bclk_pkg::MAX_PINS-1:0]   r_pin_en;
    logic [bclk_pkg::MAX_PINS-1:0]   r_click_en;
    logic [bclk_pkg::MAX_PINS-1:0]   r_long_en;
    logic [bclk_pkg::INTERVAL_W-1:0] r_min_interval;
    logic [bclk_pkg::INTERVAL_W-1:0] r_long_time;

    // input register
    logic                          r_in_valid;
    logic [bclk_pkg::TIME_W-1:0]   r_in_now;
    logic [bclk_pkg::MAX_PINS-1:0] r_in_port;

    // state
    logic [bclk_pkg::TIME_W-1:0] r_last_time;
    logic [LANES-1:0]            r_held;
    logic [bclk_pkg::TIME_W-1:0] r_press_time [LANES];

    logic [bclk_pkg::TIME_W-1:0] n_last_time;
    logic [LANES-1:0]            n_held;
    logic [bclk_pkg::TIME_W-1:0] n_press_time [LANES];

    // output register
    logic              r_out_valid;
    bclk_pkg::t_result r_out;
    bclk_pkg::t_result n_out;

    logic                        advance;
    logic                        taken;
    logic [bclk_pkg::TIME_W-1:0] elapsed;
    logic [bclk_pkg::TIME_W-1:0] held_time [LANES];

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_out};

    assign elapsed = r_in_now - r_last_time;
    assign taken   = elapsed > {{(bclk_pkg::TIME_W - bclk_pkg::INTERVAL_W){1'b0}},
                                r_min_interval};

    always_comb begin
        n_last_time = r_last_time;
        n_held      = r_held;
        n_out       = '0;
        if (taken) begin
            n_last_time        = r_in_now;
            n_out.sample_taken = 1'b1;
        end
        for (int i = 0; i < LANES; i++) begin
            n_press_time[i] = r_press_time[i];
            held_time[i]    = r_in_now - r_press_time[i];
            if (taken && r_pin_en[i]) begin
                if (r_in_port[i]) begin
                    if (r_held[i]) begin
                        n_held[i] = 1'b0;
                        if (held_time[i] >= {{(bclk_pkg::TIME_W - bclk_pkg::INTERVAL_W){1'b0}},
                                             r_long_time}) begin
                            n_out.long_click_mask[i] = r_long_en[i];
                        end else begin
                            n_out.click_mask[i] = r_click_en[i];
                        end
                    end
                end else if (!r_held[i]) begin
                    n_held[i]       = 1'b1;
                    n_press_time[i] = r_in_now;
                end
            end
        end
        n_out.pressed_mask[LANES-1:0] = n_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin_en       <= '0;
            r_click_en     <= '0;
            r_long_en      <= '0;
            r_min_interval <= bclk_pkg::MIN_INTERVAL_RESET;
            r_long_time    <= bclk_pkg::LONG_TIME_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bclk_pkg::REG_PIN_ENABLE:   r_pin_en       <= i_cfg_data[bclk_pkg::MAX_PINS-1:0];
                bclk_pkg::REG_CLICK_ENABLE: r_click_en     <= i_cfg_data[bclk_pkg::MAX_PINS-1:0];
                bclk_pkg::REG_LONG_ENABLE:  r_long_en      <= i_cfg_data[bclk_pkg::MAX_PINS-1:0];
                bclk_pkg::REG_MIN_INTERVAL: r_min_interval <= i_cfg_data;
                bclk_pkg::REG_LONG_TIME:    r_long_time    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_last_time <= '0;
            r_held      <= '0;
            for (int i = 0; i < LANES; i++) begin
                r_press_time[i] <= '0;
            end
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_last_time <= n_last_time;
                r_held      <= n_held;
                for (int i = 0; i < LANES; i++) begin
                    r_press_time[i] <= n_press_time[i];
                end
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_now  <= i_s_tdata[bclk_pkg::TIME_W-1:0];
            r_in_port <= i_s_tdata[bclk_pkg::TIME_W +: bclk_pkg::MAX_PINS];
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    // a rejected sample reports no event
    a_no_event_unless_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.sample_taken |->
            r_out.click_mask == '0 && r_out.long_click_mask == '0)
        else $error("event reported on a rejected sample");

    // one release is either short or long
    a_click_kinds_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.click_mask & r_out.long_click_mask) == '0)
        else $error("pin reported as both click and long click");

    // a reported pin has been released
    a_event_pin_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |->
            ((r_out.click_mask | r_out.long_click_mask) & r_out.pressed_mask) == '0)
        else $error("event on a pin that is still held");

    // events only where enabled
    a_event_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.click_mask & ~(r_click_en & r_pin_en)) == '0 &&
                        (r_out.long_click_mask & ~(r_long_en & r_pin_en)) == '0)
        else $error("event on a disabled pin");

    // a rejected sample leaves the state alone
    a_reject_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !taken |=> $stable(r_last_time) && $stable(r_held))
        else $error("state changed on a rejected sample");

endmodule
